### hdl/sgbi_pkg.sv
// ----------------------------------------------------------------------------
// sgbi_pkg
// Shared constants, codes and controller/datapath interface types for the
// softened gravity body integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgbi_pkg;

    localparam int unsigned DEF_FRAC_BITS   = 16;
    localparam int unsigned DEF_DATA_WIDTH  = 32;
    localparam int unsigned DEF_RSQRT_ITERS = 3;

    // configuration register indexes
    localparam logic [1:0] REG_GRAV = 2'd0;
    localparam logic [1:0] REG_DT   = 2'd1;
    localparam logic [1:0] REG_SOFT = 2'd2;

    localparam logic [31:0] RST_GRAV = 32'd65536;
    localparam logic [31:0] RST_DT   = 32'd655;
    localparam logic [31:0] RST_SOFT = 32'd2621;

    // multiplier phases
    localparam logic [1:0] PH_LO = 2'd0;
    localparam logic [1:0] PH_HI = 2'd1;
    localparam logic [1:0] PH_WB = 2'd2;

    // multiply operations: operands and write-back target
    localparam logic [3:0] MOP_DD  = 4'd0;  // d*d      -> s +=
    localparam logic [3:0] MOP_YY  = 4'd1;  // y*y      -> t
    localparam logic [3:0] MOP_ST  = 4'd2;  // s*t      -> h = 3 - p
    localparam logic [3:0] MOP_YH  = 4'd3;  // y*h      -> y = p/2
    localparam logic [3:0] MOP_GM  = 4'd4;  // G*m      -> f
    localparam logic [3:0] MOP_FD  = 4'd5;  // f*d      -> t
    localparam logic [3:0] MOP_TY  = 4'd6;  // t*y      -> t
    localparam logic [3:0] MOP_TYA = 4'd7;  // t*y      -> acc +=
    localparam logic [3:0] MOP_AD  = 4'd8;  // acc*dt   -> vel +=
    localparam logic [3:0] MOP_VD  = 4'd9;  // vel*dt   -> pos +=

    typedef struct packed {
        logic       load;
        logic       start;
        logic       mul;
        logic [1:0] ph;
        logic [3:0] mop;
        logic [1:0] ax;
        logic       soft_add;
        logic       scan_init;
        logic       scan_step;
        logic       y_init;
        logic       y_zero;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic s_zero;
        logic scan_top;
    } t_sts;

endpackage

`default_nettype wire

### hdl/softened_gravity_body_integrator_core.sv
// ----------------------------------------------------------------------------
// softened_gravity_body_integrator_core
// One body's softened-gravity accumulation and symplectic Euler update in
// signed fixed point, with a sequencer driving a shared-multiplier datapath.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall  | action, coord xyz, speed xyz, mass,
//           |                          | last_of_sweep
//  output   | o_out_valid / i_out_stall| new_pos xyz, new_vel xyz
//  config   | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  An interact word runs distance, leading-one scan, RSQRT_ITERS Newton
//  steps and force; every multiply walks lo, hi and write-back phases
//  on one shared half-width multiplier and the leading-one scan moves
//  one bit a cycle. A last word adds the velocity and position updates.
//  Reset is synchronous; it clears state and restores register defaults.
//  The finished word sits in an output register, so the next input word
//  is taken while it is stalled; a second result waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_gravity_body_integrator_core
    import sgbi_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS,
    parameter int unsigned DATA_WIDTH  = DEF_DATA_WIDTH,
    parameter int unsigned RSQRT_ITERS = DEF_RSQRT_ITERS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_action,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic signed [31:0] i_speed_x,
    input  wire logic signed [31:0] i_speed_y,
    input  wire logic signed [31:0] i_speed_z,
    input  wire logic [31:0]        i_other_mass,
    input  wire logic               i_last_of_sweep,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_pos_z,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic signed [31:0]      o_new_vel_z
);

    t_cmd w_cmd;
    t_sts w_sts;

    sgbi_ctl #(
        .RSQRT_ITERS(RSQRT_ITERS)
    ) u_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_action       (i_action),
        .i_last_of_sweep(i_last_of_sweep),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    sgbi_dp #(
        .FRAC_BITS (FRAC_BITS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_speed_x   (i_speed_x),
        .i_speed_y   (i_speed_y),
        .i_speed_z   (i_speed_z),
        .i_other_mass(i_other_mass),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_new_pos_x (o_new_pos_x),
        .o_new_pos_y (o_new_pos_y),
        .o_new_pos_z (o_new_pos_z),
        .o_new_vel_x (o_new_vel_x),
        .o_new_vel_y (o_new_vel_y),
        .o_new_vel_z (o_new_vel_z)
    );

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result emitted over a stalled word");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("emitted word not presented");

    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul && w_cmd.ph == PH_HI) |-> ($past(w_cmd.mul) && $past(w_cmd.ph) == PH_LO))
        else $error("multiplier high phase without low phase");

endmodule

`default_nettype wire

### hdl/sgbi_ctl.sv
// ----------------------------------------------------------------------------
// sgbi_ctl
// Sequencer: steps the datapath through load, interaction, inverse square
// root and integration, one multiply phase per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbi_ctl
    import sgbi_pkg::*;
#(
    parameter int unsigned RSQRT_ITERS = DEF_RSQRT_ITERS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_action,
    input  wire logic i_last_of_sweep,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam int unsigned IW = $clog2(RSQRT_ITERS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DSQ   = 4'd1;
    localparam logic [3:0] S_SOFT  = 4'd2;
    localparam logic [3:0] S_SCAN0 = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_NEWT  = 4'd5;
    localparam logic [3:0] S_FMUL  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_VEL   = 4'd8;
    localparam logic [3:0] S_POS   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_ph, n_ph;
    logic [1:0]    r_ax, n_ax;
    logic [1:0]    r_op, n_op;
    logic [IW-1:0] r_it, n_it;
    logic          r_last, n_last;
    logic          r_out_valid, n_out_valid;
    logic          w_free;
    logic          w_wb;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_wb        = (r_ph == PH_WB);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_ax        = r_ax;
        n_op        = r_op;
        n_it        = r_it;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.ph    = r_ph;
        o_cmd.ax    = r_ax;

        // every multiply state walks lo, hi, write-back
        if (r_state == S_DSQ || r_state == S_NEWT || r_state == S_FMUL ||
            r_state == S_ACC || r_state == S_VEL || r_state == S_POS) begin
            o_cmd.mul = 1'b1;
            n_ph      = w_wb ? PH_LO : r_ph + 2'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        o_cmd.start = 1'b1;
                        n_last      = i_last_of_sweep;
                        n_ax        = 2'd0;
                        n_ph        = PH_LO;
                        n_state     = S_DSQ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DSQ: begin
                o_cmd.mop = MOP_DD;
                if (w_wb) begin
                    n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) n_state = S_SOFT;
                end
            end
            S_SOFT: begin
                o_cmd.soft_add = 1'b1;
                n_state        = S_SCAN0;
            end
            S_SCAN0: begin
                // zero radicand: inverse root is zero, skip Newton
                if (i_sts.s_zero) begin
                    o_cmd.y_zero = 1'b1;
                    n_state      = S_FMUL;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_top) begin
                    o_cmd.y_init = 1'b1;
                    n_op         = 2'd0;
                    n_it         = '0;
                    n_state      = S_NEWT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_NEWT: begin
                case (r_op)
                    2'd0:    o_cmd.mop = MOP_YY;
                    2'd1:    o_cmd.mop = MOP_ST;
                    default: o_cmd.mop = MOP_YH;
                endcase
                if (w_wb) begin
                    if (r_op == 2'd2) begin
                        n_op = 2'd0;
                        if (r_it == IW'(RSQRT_ITERS - 1)) n_state = S_FMUL;
                        else                              n_it = r_it + IW'(1);
                    end else begin
                        n_op = r_op + 2'd1;
                    end
                end
            end
            S_FMUL: begin
                o_cmd.mop = MOP_GM;
                if (w_wb) begin
                    n_ax    = 2'd0;
                    n_op    = 2'd0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                case (r_op)
                    2'd0:    o_cmd.mop = MOP_FD;
                    2'd3:    o_cmd.mop = MOP_TYA;
                    default: o_cmd.mop = MOP_TY;
                endcase
                if (w_wb) begin
                    n_op = r_op + 2'd1;
                    if (r_op == 2'd3) begin
                        n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                        if (r_ax == 2'd2) n_state = r_last ? S_VEL : S_IDLE;
                    end
                end
            end
            S_VEL: begin
                o_cmd.mop = MOP_AD;
                if (w_wb) begin
                    n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) n_state = S_POS;
                end
            end
            S_POS: begin
                o_cmd.mop = MOP_VD;
                if (w_wb) begin
                    n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output word slot is free
                if (w_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= PH_LO;
            r_ax        <= 2'd0;
            r_op        <= 2'd0;
            r_it        <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_ax        <= n_ax;
            r_op        <= n_op;
            r_it        <= n_it;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hdl/sgbi_dp.sv
// ----------------------------------------------------------------------------
// sgbi_dp
// Datapath: body state, configuration registers, one shared half-width
// multiplier with saturating fixed-point post-processing, leading-one scan.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbi_dp
    import sgbi_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS,
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic signed [31:0] i_speed_x,
    input  wire logic signed [31:0] i_speed_y,
    input  wire logic signed [31:0] i_speed_z,
    input  wire logic [31:0]        i_other_mass,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_pos_z,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic signed [31:0]      o_new_vel_z
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned H  = (W + 1) / 2;
    localparam int unsigned CW = $clog2(W);

    localparam logic signed [63:0] VMAX64  = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64  = -VMAX64 - 64'sd1;
    localparam logic signed [63:0] THREE_R = 64'sd3 <<< F;
    localparam logic signed [63:0] THREE64 = (THREE_R > VMAX64) ? VMAX64 : THREE_R;
    localparam logic signed [W-1:0] VMAX   = VMAX64[W-1:0];
    localparam logic signed [W-1:0] VMIN   = VMIN64[W-1:0];
    localparam logic signed [W-1:0] THREE  = THREE64[W-1:0];
    localparam logic [2*W-1:0] LIM_POS     = (2*W)'(VMAX64);
    localparam logic [2*W-1:0] LIM_NEG     = LIM_POS + (2*W)'(1);

    function automatic logic signed [W-1:0] sat64(input logic signed [63:0] v);
        if (v > VMAX64) return VMAX;
        if (v < VMIN64) return VMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] from_s32(input logic [31:0] x);
        return sat64(64'(signed'(x)));
    endfunction

    function automatic logic signed [W-1:0] from_u32(input logic [31:0] x);
        return sat64(signed'({32'd0, x}));
    endfunction

    function automatic logic signed [31:0] to_out(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'sd2147483647)  return 32'sh7fffffff;
        if (e < -64'sd2147483648) return 32'sh80000000;
        return e[31:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
        return s[W-1:0];
    endfunction

    logic signed [W-1:0] r_pos [3];
    logic signed [W-1:0] r_vel [3];
    logic signed [W-1:0] r_acc [3];
    logic signed [W-1:0] r_d   [3];
    logic signed [W-1:0] r_s, r_y, r_t, r_h, r_f, r_mass;
    logic [31:0]         r_grav, r_dt, r_soft;
    logic [W-1:0]        r_scan;
    logic [CW-1:0]       r_cnt;
    logic [W+H-1:0]      r_plo;
    logic [2*W-1:0]      r_prod;
    logic signed [31:0]  r_opx, r_opy, r_opz, r_ovx, r_ovy, r_ovz;

    logic signed [W-1:0] w_a, w_b, w_res, w_half;
    logic [W-1:0]        w_ma, w_mb, w_mag;
    logic [H-1:0]        w_bsel;
    logic [W+H-1:0]      w_p;
    logic [2*W-1:0]      w_shr, w_lim;
    logic                w_neg;
    logic signed [7:0]   w_e, w_c, w_k;
    logic [5:0]          w_kc;
    logic signed [31:0]  w_cin [3];
    logic signed [31:0]  w_vin [3];

    assign w_cin[0] = i_coord_x;
    assign w_cin[1] = i_coord_y;
    assign w_cin[2] = i_coord_z;
    assign w_vin[0] = i_speed_x;
    assign w_vin[1] = i_speed_y;
    assign w_vin[2] = i_speed_z;

    // operand selection
    always_comb begin
        unique case (i_cmd.mop)
            MOP_DD:  begin w_a = r_d[i_cmd.ax];     w_b = r_d[i_cmd.ax];  end
            MOP_YY:  begin w_a = r_y;               w_b = r_y;            end
            MOP_ST:  begin w_a = r_s;               w_b = r_t;            end
            MOP_YH:  begin w_a = r_y;               w_b = r_h;            end
            MOP_GM:  begin w_a = from_u32(r_grav);  w_b = r_mass;         end
            MOP_FD:  begin w_a = r_f;               w_b = r_d[i_cmd.ax];  end
            MOP_TY,
            MOP_TYA: begin w_a = r_t;               w_b = r_y;            end
            MOP_AD:  begin w_a = r_acc[i_cmd.ax];   w_b = from_u32(r_dt); end
            MOP_VD:  begin w_a = r_vel[i_cmd.ax];   w_b = from_u32(r_dt); end
            default: begin w_a = '0;                w_b = '0;             end
        endcase
    end

    // sign-magnitude product, low half of b then high half
    always_comb begin
        w_neg  = w_a[W-1] ^ w_b[W-1];
        w_ma   = w_a[W-1] ? W'(-w_a) : W'(w_a);
        w_mb   = w_b[W-1] ? W'(-w_b) : W'(w_b);
        w_bsel = (i_cmd.ph == PH_LO) ? w_mb[H-1:0] : H'(w_mb[W-1:H]);
        w_p    = (W+H)'(w_ma) * (W+H)'(w_bsel);
        w_shr  = r_prod >> F;
        w_lim  = w_neg ? LIM_NEG : LIM_POS;
        w_mag  = (w_shr > w_lim) ? w_lim[W-1:0] : w_shr[W-1:0];
        w_res  = w_neg ? signed'(-w_mag) : signed'(w_mag);
        // halve toward zero
        w_half = (w_res + $signed(W'(w_res[W-1]))) >>> 1;
    end

    // initial guess exponent from the leading one position
    always_comb begin
        w_e  = signed'(8'(r_cnt)) - signed'(8'(F));
        w_c  = (w_e + 8'sd1) >>> 1;
        w_k  = signed'(8'(F)) - w_c;
        if (w_k < 8'sd0)                    w_kc = 6'd0;
        else if (w_k > signed'(8'(W - 2))) w_kc = 6'(W - 2);
        else                                w_kc = w_k[5:0];
    end

    assign o_sts.s_zero   = (r_s == '0);
    assign o_sts.scan_top = r_scan[W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= RST_GRAV;
            r_dt   <= RST_DT;
            r_soft <= RST_SOFT;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GRAV: r_grav <= i_cfg_data;
                    REG_DT:   r_dt   <= i_cfg_data;
                    REG_SOFT: r_soft <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    r_pos[i] <= from_s32(w_cin[i]);
                    r_vel[i] <= from_s32(w_vin[i]);
                    r_acc[i] <= '0;
                end
            end
            if (i_cmd.mul && i_cmd.ph == PH_WB) begin
                case (i_cmd.mop)
                    MOP_TYA: r_acc[i_cmd.ax] <= sadd(r_acc[i_cmd.ax], w_res);
                    MOP_AD:  r_vel[i_cmd.ax] <= sadd(r_vel[i_cmd.ax], w_res);
                    MOP_VD:  r_pos[i_cmd.ax] <= sadd(r_pos[i_cmd.ax], w_res);
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 3; i++) r_d[i] <= ssub(from_s32(w_cin[i]), r_pos[i]);
            r_mass <= from_u32(i_other_mass);
            r_s    <= '0;
        end
        if (i_cmd.soft_add) r_s <= sadd(r_s, from_u32(r_soft));
        if (i_cmd.scan_init) begin
            r_scan <= r_s;
            r_cnt  <= CW'(W - 1);
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan << 1;
            r_cnt  <= r_cnt - CW'(1);
        end
        if (i_cmd.y_init) r_y <= W'(1) << w_kc;
        if (i_cmd.y_zero) r_y <= '0;
        if (i_cmd.mul) begin
            if (i_cmd.ph == PH_LO) r_plo <= w_p;
            if (i_cmd.ph == PH_HI) r_prod <= (2*W)'(r_plo) + ((2*W)'(w_p) << H);
            if (i_cmd.ph == PH_WB) begin
                case (i_cmd.mop)
                    MOP_DD:  r_s <= sadd(r_s, w_res);
                    MOP_YY,
                    MOP_FD,
                    MOP_TY:  r_t <= w_res;
                    MOP_ST:  r_h <= ssub(THREE, w_res);
                    MOP_YH:  r_y <= w_half;
                    MOP_GM:  r_f <= w_res;
                    default: ;
                endcase
            end
        end
        if (i_cmd.emit) begin
            r_opx <= to_out(r_pos[0]);
            r_opy <= to_out(r_pos[1]);
            r_opz <= to_out(r_pos[2]);
            r_ovx <= to_out(r_vel[0]);
            r_ovy <= to_out(r_vel[1]);
            r_ovz <= to_out(r_vel[2]);
        end
    end

    assign o_new_pos_x = r_opx;
    assign o_new_pos_y = r_opy;
    assign o_new_pos_z = r_opz;
    assign o_new_vel_x = r_ovx;
    assign o_new_vel_y = r_ovy;
    assign o_new_vel_z = r_ovz;

endmodule

`default_nettype wire
